FILE: hdl/adam_parameter_update_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Adam parameter update core
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ADAM_PARAMETER_UPDATE_CORE_ASSERT_SVH
`define ADAM_PARAMETER_UPDATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, switched off while reset is asserted.
`define APU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds across reset.
`define APU_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APU_ASSERT(lbl, clk, rstn, prop, msg)
`define APU_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/adampu_pkg.sv
// ----------------------------------------------------------------------------
// Adam parameter update package
// Widths, register reset values, register map and shared pipeline types.
// ----------------------------------------------------------------------------
package adampu_pkg;

  localparam int IDX_W    = 10;
  localparam int DATA_W   = 32;
  localparam int MOM_W    = 48;
  localparam int LR_W     = 24;
  localparam int DECAY_W  = 16;
  localparam int CORR_W   = 32;
  localparam int CFG_AW   = 5;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 48;

  localparam int PARAM_COUNT_DEF = 1024;

  // Register reset values.
  localparam logic [LR_W-1:0]    LR_RST = 24'd16777;
  localparam logic [DECAY_W-1:0] B1_RST = 16'd58982;
  localparam logic [DECAY_W-1:0] B2_RST = 16'd65470;
  localparam logic [CORR_W-1:0]  C1_RST = 32'd655360;
  localparam logic [CORR_W-1:0]  C2_RST = 32'd65536000;

  // Epsilon 0.000001 in unsigned Q.32.
  localparam logic [63:0] EPS_Q32 = 64'd4295;

  // Register map, word index on the configuration port.
  typedef enum logic [2:0] {
    REG_LEARN_RATE   = 3'd0,
    REG_DECAY_FIRST  = 3'd1,
    REG_DECAY_SECOND = 3'd2,
    REG_FIRST_CORR   = 3'd3,
    REG_SECOND_CORR  = 3'd4
  } cfg_reg_t;

  // Side information that travels with an item down the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] weight;
    logic                     neg;
  } tag_t;

  // Pipeline control handed to the root and divide unit.
  typedef struct packed {
    logic adv;
    logic valid;
  } pipe_ctl_t;

  // One step of the square root.
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } sq_state_t;

  // One step of the divider.
  typedef struct packed {
    logic [31:0] root;
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] q;
    logic        big;
  } dv_state_t;

endpackage

FILE: hdl/adampu_root_div.sv
// ----------------------------------------------------------------------------
// Adam update root and divide unit
// Pipelined integer square root followed by a pipelined restoring divider.
// ----------------------------------------------------------------------------
module adampu_root_div import adampu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pipe_ctl_t   ctl,
  input  logic [63:0] x_in,
  input  logic [63:0] num_in,
  input  tag_t        tag_in,
  output logic        res_valid,
  output logic [31:0] quo,
  output logic        big,
  output tag_t        tag_out
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;

  sq_state_t   sq_r     [SQ_STEPS];
  logic [63:0] sq_num_r [SQ_STEPS];
  tag_t        sq_tag_r [SQ_STEPS];
  dv_state_t   dv_r     [DIV_STEPS+1];
  tag_t        dv_tag_r [DIV_STEPS+1];
  logic [SQ_STEPS-1:0] sq_v_r;
  logic [DIV_STEPS:0]  dv_v_r;
  dv_state_t   dv_init;

  // One digit of the bitwise square root; the test bit is fixed per stage.
  function automatic sq_state_t sq_step(input sq_state_t s, input int k);
    logic [63:0] bitv;
    logic [63:0] trial;
    sq_state_t   r;
    bitv  = 64'd1 << (62 - 2 * k);
    trial = s.res + bitv;
    if (s.x >= trial) begin
      r.x   = s.x - trial;
      r.res = (s.res >> 1) + bitv;
    end else begin
      r.x   = s.x;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  // One quotient bit of the restoring divider.
  function automatic dv_state_t dv_step(input dv_state_t s, input int b);
    logic [32:0] t;
    dv_state_t   r;
    r = s;
    t = {s.rem, s.low[b]};
    if (t >= {1'b0, s.root}) begin
      t      = t - {1'b0, s.root};
      r.q[b] = 1'b1;
    end
    r.rem = t[31:0];
    return r;
  endfunction

  // Division setup: the high half of the numerator must stay below the root.
  always_comb begin
    dv_init.root = sq_r[SQ_STEPS-1].res[31:0];
    dv_init.rem  = sq_num_r[SQ_STEPS-1][63:32];
    dv_init.low  = sq_num_r[SQ_STEPS-1][31:0];
    dv_init.q    = '0;
    dv_init.big  = (sq_num_r[SQ_STEPS-1][63:32] >= sq_r[SQ_STEPS-1].res[31:0]);
  end

  // Datapath stages, all moving together.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      sq_r[0]     <= sq_step('{x: x_in, res: 64'd0}, 0);
      sq_num_r[0] <= num_in;
      sq_tag_r[0] <= tag_in;
      for (int k = 1; k < SQ_STEPS; k++) begin
        sq_r[k]     <= sq_step(sq_r[k-1], k);
        sq_num_r[k] <= sq_num_r[k-1];
        sq_tag_r[k] <= sq_tag_r[k-1];
      end
      dv_r[0]     <= dv_init;
      dv_tag_r[0] <= sq_tag_r[SQ_STEPS-1];
      for (int j = 1; j <= DIV_STEPS; j++) begin
        dv_r[j]     <= dv_step(dv_r[j-1], DIV_STEPS - j);
        dv_tag_r[j] <= dv_tag_r[j-1];
      end
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
      dv_v_r <= '0;
    end else if (ctl.adv) begin
      sq_v_r <= {sq_v_r[SQ_STEPS-2:0], ctl.valid};
      dv_v_r <= {dv_v_r[DIV_STEPS-1:0], sq_v_r[SQ_STEPS-1]};
    end
  end

  assign res_valid = dv_v_r[DIV_STEPS];
  assign quo       = dv_r[DIV_STEPS].q;
  assign big       = dv_r[DIV_STEPS].big;
  assign tag_out   = dv_tag_r[DIV_STEPS];

endmodule

FILE: hdl/adam_parameter_update_core.sv
// ----------------------------------------------------------------------------
// Adam parameter update core
// Updates the Adam moments of one parameter per transaction and returns the
// new weight.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream: one parameter update per transaction (index, bias flag,
//         delta, activation, current weight).
//   out_* stream: one transaction per input, in order: new weight and index.
//   cfg_* port:   APB-style access to learning rate, decay rates and the two
//         bias corrections; write them only while the core is idle.
// Throughput is one transaction per cycle while the output buffer has room.
// The path from input to output runs through the 13 front stages, the
// 32-stage square root, the 33-stage divider and the output buffer register.
// The moment memories are read one stage before the update stage and
// written at its end; a back-to-back update of the same index is forwarded.
// After reset the core clears both moment memories, one entry per cycle,
// over all PARAM_COUNT entries (1024 by default) with in_tready low.
// A two-entry output buffer lets the core accept one more transaction while
// a result waits; when it is full the whole pipeline holds and in_tready
// falls.
// ----------------------------------------------------------------------------
module adam_parameter_update_core import adampu_pkg::*; #(
  parameter int PARAM_COUNT = PARAM_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // param_index[9:0], delta[41:10], activation[73:42], current_weight[105:74]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // is_bias[0]
  input  logic                   in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // new_weight[31:0], result_index[41:32]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration port.
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  `include "adam_parameter_update_core_assert.svh"

  localparam int AW = $clog2(PARAM_COUNT);

  // Configuration registers.
  logic [LR_W-1:0]    lr_r;
  logic [DECAY_W-1:0] b1_r, b2_r;
  logic [CORR_W-1:0]  c1_r, c2_r;
  cfg_reg_t           cfg_sel;
  logic               cfg_wr;

  // Pipeline control.
  logic        adv;
  logic        in_acc;
  logic [13:1] v_r;
  tag_t        tag_r [1:13];
  logic [AW-1:0] addr_r [2:8];

  // Memory clear.
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  // Datapath registers.
  logic               bias1_r, bias2_r;
  logic signed [31:0] delta1_r, act1_r, delta2_r;
  logic signed [63:0] prod2_r;
  logic signed [47:0] g3_r;
  logic signed [64:0] gq4_r, gq5_r, gq6_r, gq7_r, gq8_r;
  logic [47:0]        gmag4_r;
  logic               sqsat5_r;
  logic [59:0]        p1_5_r, p0_5_r;
  logic [47:0]        sq6_r;
  logic [64:0]        vq7_r, vq8_r;
  logic [47:0]        m_rd_r, v_rd_r;
  logic signed [47:0] m9_r;
  logic [47:0]        v9_r;
  logic [55:0]        pm_hi10_r, pm_lo10_r, pv_hi10_r, pv_lo10_r;
  logic [63:0]        mhat11_r, vhat11_r;
  logic [63:0]        x12_r, x13_r;
  logic [55:0]        pn_hi12_r, pn_lo12_r;
  logic [63:0]        num13_r;

  // Moment memories and write-back forwarding.
  logic [47:0]   m_mem [PARAM_COUNT];
  logic [47:0]   v_mem [PARAM_COUNT];
  logic          wbv_r;
  logic [AW-1:0] wb_addr_r;
  logic [47:0]   wb_m_r, wb_v_r;

  // Combinational datapath signals.
  logic [AW-1:0]      addr1;
  logic [16:0]        b1c, b2c;
  logic signed [47:0] g_nxt;
  logic signed [64:0] gq_nxt;
  logic [79:0]        sq_full;
  logic [64:0]        vq_nxt;
  logic               fwd_hit;
  logic signed [47:0] m_old;
  logic [47:0]        v_old;
  logic signed [65:0] m_sum;
  logic [65:0]        v_sum;
  logic signed [47:0] m_new;
  logic [47:0]        v_new;
  logic [47:0]        mmag;
  logic [79:0]        pm_full, pv_full;
  logic [64:0]        x_sum;
  logic [87:0]        pn_full;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [47:0]        mem_wm, mem_wv;

  // Root and divide results.
  pipe_ctl_t   rd_ctl;
  logic        rd_valid;
  logic [31:0] rd_quo;
  logic        rd_big;
  tag_t        rd_tag;
  logic [35:0] step;
  logic [35:0] w36, nw36;
  logic [31:0] nw;

  // Output buffer.
  logic [1:0]             ocnt_r;
  logic [OUT_TDATA_W-1:0] e0_r, e1_r;
  logic [OUT_TDATA_W-1:0] res_word;
  logic                   push, pop;

  // Index to memory address, wrapping at the store depth.
  function automatic logic [AW-1:0] wrap_index(input logic [IDX_W-1:0] pidx);
    logic [IDX_W-1:0] r;
    r = pidx;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if ({{(64-IDX_W){1'b0}}, r} >= (64'(PARAM_COUNT) << k)) begin
        r = r - IDX_W'(64'(PARAM_COUNT) << k);
      end
    end
    return AW'(r);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RST;
      b1_r <= B1_RST;
      b2_r <= B2_RST;
      c1_r <= C1_RST;
      c2_r <= C2_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LEARN_RATE:   lr_r <= cfg_pwdata[LR_W-1:0];
        REG_DECAY_FIRST:  b1_r <= cfg_pwdata[DECAY_W-1:0];
        REG_DECAY_SECOND: b2_r <= cfg_pwdata[DECAY_W-1:0];
        REG_FIRST_CORR:   c1_r <= cfg_pwdata;
        REG_SECOND_CORR:  c2_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_LEARN_RATE:   cfg_prdata = {8'd0, lr_r};
      REG_DECAY_FIRST:  cfg_prdata = {16'd0, b1_r};
      REG_DECAY_SECOND: cfg_prdata = {16'd0, b2_r};
      REG_FIRST_CORR:   cfg_prdata = c1_r;
      REG_SECOND_CORR:  cfg_prdata = c2_r;
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: everything moves while the output buffer has room.
  // ---------------------------------------------------------------------
  assign adv       = (ocnt_r != 2'd2);
  assign in_tready = adv & ~clr_busy_r;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[12:1], in_acc};
    end
  end

  // Memory clear sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(PARAM_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Gradient, its square and the weighted new-sample terms.
  // ---------------------------------------------------------------------
  assign addr1 = wrap_index(tag_r[1].idx);
  assign b1c   = 17'h10000 - {1'b0, b1_r};
  assign b2c   = 17'h10000 - {1'b0, b2_r};

  always_comb begin
    if (bias2_r) begin
      g_nxt = {delta2_r, 16'h0000};
    end else if ((prod2_r[63:47] == '0) || (prod2_r[63:47] == '1)) begin
      g_nxt = prod2_r[47:0];
    end else if (prod2_r[63]) begin
      g_nxt = {1'b1, 47'd0};
    end else begin
      g_nxt = {1'b0, {47{1'b1}}};
    end
  end

  assign gq_nxt  = $signed({1'b0, b1c}) * g3_r;
  assign sq_full = {p1_5_r, 20'd0} + {20'd0, p0_5_r};
  assign vq_nxt  = {48'd0, b2c} * {17'd0, sq6_r};

  // ---------------------------------------------------------------------
  // Moment update with forwarding of the previous update's write.
  // ---------------------------------------------------------------------
  assign fwd_hit = wbv_r && (wb_addr_r == addr_r[8]);
  assign m_old   = fwd_hit ? wb_m_r : m_rd_r;
  assign v_old   = fwd_hit ? wb_v_r : v_rd_r;
  assign m_sum   = $signed({1'b0, b1_r}) * m_old + gq8_r;
  assign v_sum   = {50'd0, b2_r} * {18'd0, v_old} + {1'b0, vq8_r};
  assign m_new   = m_sum[63:16];
  assign v_new   = v_sum[63:16];

  assign mem_we = clr_busy_r | (adv & v_r[8]);
  assign mem_wa = clr_busy_r ? clr_cnt_r : addr_r[8];
  assign mem_wm = clr_busy_r ? 48'd0 : m_new;
  assign mem_wv = clr_busy_r ? 48'd0 : v_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      m_mem[mem_wa] <= mem_wm;
      v_mem[mem_wa] <= mem_wv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_rd_r <= m_mem[addr_r[7]];
      v_rd_r <= v_mem[addr_r[7]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbv_r <= 1'b0;
    end else if (adv) begin
      wbv_r <= v_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wb_addr_r <= addr_r[8];
      wb_m_r    <= m_new;
      wb_v_r    <= v_new;
    end
  end

  // ---------------------------------------------------------------------
  // Bias corrections, epsilon and the step numerator.
  // ---------------------------------------------------------------------
  assign mmag    = m9_r[47] ? 48'(-m9_r) : 48'(m9_r);
  assign pm_full = {pm_hi10_r, 24'd0} + {24'd0, pm_lo10_r};
  assign pv_full = {pv_hi10_r, 24'd0} + {24'd0, pv_lo10_r};
  assign x_sum   = {1'b0, vhat11_r} + {1'b0, EPS_Q32};
  assign pn_full = {pn_hi12_r, 32'd0} + {32'd0, pn_lo12_r};

  // Datapath stage registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[1] <= '{idx: in_tdata[9:0], weight: in_tdata[105:74], neg: 1'b0};
      bias1_r  <= in_tuser;
      delta1_r <= in_tdata[41:10];
      act1_r   <= in_tdata[73:42];
      for (int s = 2; s <= 8; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
      tag_r[9]  <= '{idx: tag_r[8].idx, weight: tag_r[8].weight, neg: m_new[47]};
      for (int s = 10; s <= 13; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
      addr_r[2] <= addr1;
      for (int s = 3; s <= 8; s++) begin
        addr_r[s] <= addr_r[s-1];
      end
      // Gradient.
      bias2_r  <= bias1_r;
      delta2_r <= delta1_r;
      prod2_r  <= delta1_r * act1_r;
      g3_r     <= g_nxt;
      gq4_r    <= gq_nxt;
      gmag4_r  <= g3_r[47] ? 48'(-g3_r) : 48'(g3_r);
      // Square of the gradient in two partial products.
      gq5_r    <= gq4_r;
      sqsat5_r <= (gmag4_r[47:40] != 8'd0);
      p1_5_r   <= {20'd0, gmag4_r[39:0]} * {40'd0, gmag4_r[39:20]};
      p0_5_r   <= {20'd0, gmag4_r[39:0]} * {40'd0, gmag4_r[19:0]};
      gq6_r    <= gq5_r;
      sq6_r    <= sqsat5_r ? {48{1'b1}} : sq_full[79:32];
      gq7_r    <= gq6_r;
      vq7_r    <= vq_nxt;
      gq8_r    <= gq7_r;
      vq8_r    <= vq7_r;
      // Updated moments.
      m9_r     <= m_new;
      v9_r     <= v_new;
      // Corrections in split products.
      pm_hi10_r <= {32'd0, mmag[47:24]} * {24'd0, c1_r};
      pm_lo10_r <= {32'd0, mmag[23:0]} * {24'd0, c1_r};
      pv_hi10_r <= {32'd0, v9_r[47:24]} * {24'd0, c2_r};
      pv_lo10_r <= {32'd0, v9_r[23:0]} * {24'd0, c2_r};
      mhat11_r  <= pm_full[79:16];
      vhat11_r  <= pv_full[79:16];
      x12_r     <= x_sum[64] ? {64{1'b1}} : x_sum[63:0];
      pn_hi12_r <= {32'd0, lr_r} * {24'd0, mhat11_r[63:32]};
      pn_lo12_r <= {32'd0, lr_r} * {24'd0, mhat11_r[31:0]};
      x13_r     <= x12_r;
      num13_r   <= pn_full[87:24];
    end
  end

  // ---------------------------------------------------------------------
  // Square root and division.
  // ---------------------------------------------------------------------
  assign rd_ctl = '{adv: adv, valid: v_r[13]};

  adampu_root_div u_root_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rd_ctl),
    .x_in      (x13_r),
    .num_in    (num13_r),
    .tag_in    (tag_r[13]),
    .res_valid (rd_valid),
    .quo       (rd_quo),
    .big       (rd_big),
    .tag_out   (rd_tag)
  );

  // Apply the signed step and saturate to Q16.16.
  always_comb begin
    step = rd_big ? 36'h2_0000_0000 : {4'd0, rd_quo};
    w36  = {{4{rd_tag.weight[31]}}, rd_tag.weight};
    nw36 = rd_tag.neg ? (w36 + step) : (w36 - step);
    if ((nw36[35:31] == 5'b00000) || (nw36[35:31] == 5'b11111)) begin
      nw = nw36[31:0];
    end else if (nw36[35]) begin
      nw = 32'h8000_0000;
    end else begin
      nw = 32'h7FFF_FFFF;
    end
  end

  assign res_word = {6'd0, rd_tag.idx, nw};

  // ---------------------------------------------------------------------
  // Two-entry output buffer.
  // ---------------------------------------------------------------------
  assign push       = adv & rd_valid;
  assign pop        = out_tvalid & out_tready;
  assign out_tvalid = (ocnt_r != 2'd0);
  assign out_tdata  = e0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else begin
      ocnt_r <= ocnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e0_r <= (ocnt_r == 2'd2) ? e1_r : res_word;
    end else if (push && (ocnt_r == 2'd0)) begin
      e0_r <= res_word;
    end
    if (push && ((ocnt_r == 2'd1) && !pop)) begin
      e1_r <= res_word;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `APU_ASSERT_RST(a_clear_after_reset, clk, !rst_n |=> clr_busy_r, "clear not started after reset")
  `APU_ASSERT(a_no_accept_clear, clk, rst_n, clr_busy_r |-> !in_tready, "input taken during clear")
  `APU_ASSERT(a_clear_no_update, clk, rst_n, clr_busy_r |-> (v_r == '0), "pipeline busy during clear")
  `APU_ASSERT(a_full_holds, clk, rst_n, (ocnt_r == 2'd2 && !out_tready) |=> (ocnt_r == 2'd2), "output buffer lost a result")
  `APU_ASSERT(a_ocnt_range, clk, rst_n, ocnt_r != 2'd3, "output buffer overflow")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the Adam parameter update core
// Streams parameter updates through the core under several register settings.
// A local model of the moment stores and the fixed point update predicts
// every new weight but those of directed rows that carry their own. Results
// are checked in order, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import adampu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPARAM    = 1024;
  localparam int LATENCY   = 79;
  localparam int CLEAR_CYC = 1024;
  localparam int BAD_REG_A = 5;
  localparam int BAD_REG_B = 7;
  localparam logic signed [127:0] GRAD_MAX = 128'sd140737488355327;
  localparam logic signed [127:0] GRAD_MIN = -128'sd140737488355328;
  localparam logic [127:0] U48_MAX = (128'd1 << 48) - 1;
  localparam logic [127:0] U64_MAX = (128'd1 << 64) - 1;
  localparam logic [127:0] EPS_VAL = 128'd4295;

  typedef struct {
    logic [9:0]         idx;
    logic               bias;
    logic signed [31:0] delta;
    logic signed [31:0] act;
    logic signed [31:0] weight;
  } upd_t;

  typedef struct {
    logic [31:0] weight;
    logic [9:0]  idx;
  } wres_t;

  typedef struct {
    upd_t        it;
    bit          typed;
    logic [31:0] weight;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Shadow copy of the registers and the moment stores.
  logic [23:0] lr_q;
  logic [15:0] b1_q, b2_q;
  logic [31:0] c1_q, c2_q;
  logic signed [47:0] first_mom [NPARAM];
  logic [47:0] second_mom [NPARAM];

  wres_t weight_q [$];
  int n_fail = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_phases = 0;
  bit finishing = 1'b0;

  adam_parameter_update_core DUT (.*);

  // Clock, period 20 ns.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("[adam_parameter_update_core] ERROR");
    $finish;
  end

  // Floor square root, one result bit per pass.
  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] rem, acc, bitv;
    rem = x;
    acc = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= acc + bitv) begin
        rem = rem - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // Moment update and new weight of one parameter; updates the shadow stores.
  function automatic wres_t adam_update(input upd_t it);
    logic signed [127:0] grad, mom1, acc, b1s, old1;
    logic [127:0] gabs, sq, mom2, mabs, mhat, vhat, num, den, quo;
    logic signed [63:0] nw, stepv;
    wres_t r;
    grad = it.delta;
    if (it.bias) begin
      grad = grad * 65536;
    end else begin
      grad = grad * it.act;
      if (grad > GRAD_MAX) grad = GRAD_MAX;
      if (grad < GRAD_MIN) grad = GRAD_MIN;
    end
    gabs = (grad < 0) ? -grad : grad;
    sq = (gabs * gabs) >> 32;
    if (sq > U48_MAX) sq = U48_MAX;
    b1s = {112'd0, b1_q};
    old1 = first_mom[it.idx];
    acc = b1s * old1 + (128'sd65536 - b1s) * grad;
    mom1 = acc >>> 16;
    mom2 = (b2_q * {80'd0, second_mom[it.idx]} + (128'd65536 - b2_q) * sq) >> 16;
    first_mom[it.idx] = mom1[47:0];
    second_mom[it.idx] = mom2[47:0];
    mabs = (mom1 < 0) ? -mom1 : mom1;
    mhat = (mabs * c1_q) >> 16;
    vhat = (mom2 * c2_q) >> 16;
    if (vhat > U64_MAX) vhat = U64_MAX;
    vhat = vhat + EPS_VAL;
    if (vhat > U64_MAX) vhat = U64_MAX;
    num = lr_q * mhat;
    den = {64'd0, floor_root(vhat[63:0])} << 24;
    quo = num / den;
    if (quo >= (128'd1 << 32)) quo = 128'd1 << 33;
    stepv = quo[63:0];
    nw = (mom1 < 0) ? it.weight + stepv : it.weight - stepv;
    if (nw > 64'sd2147483647) nw = 64'sd2147483647;
    if (nw < -64'sd2147483648) nw = -64'sd2147483648;
    r.weight = nw[31:0];
    r.idx = it.idx;
    return r;
  endfunction

  // Register write over the configuration port; starts and ends at a falling edge.
  task automatic reg_write(input int regno, input logic [31:0] val);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = CFG_AW'(regno * 4);
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (regno)
      REG_LEARN_RATE:   lr_q = val[23:0];
      REG_DECAY_FIRST:  b1_q = val[15:0];
      REG_DECAY_SECOND: b2_q = val[15:0];
      REG_FIRST_CORR:   c1_q = val;
      REG_SECOND_CORR:  c2_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic load_regs(input logic [23:0] lr, input logic [15:0] b1, input logic [15:0] b2,
                           input logic [31:0] c1, input logic [31:0] c2);
    // Let the pipeline drain before touching the registers.
    wait (weight_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    @(negedge clk);
    reg_write(REG_LEARN_RATE, {8'hA5, lr});
    reg_write(REG_DECAY_FIRST, {16'h5A5A, b1});
    reg_write(REG_DECAY_SECOND, {16'hFFFF, b2});
    reg_write(REG_FIRST_CORR, c1);
    reg_write(REG_SECOND_CORR, c2);
    reg_write(BAD_REG_A, $urandom());
    reg_write(BAD_REG_B, $urandom());
    n_phases++;
  endtask

  // One input transaction; starts and ends at a falling edge.
  task automatic send_update(input upd_t it, input bit typed, input logic [31:0] tw);
    wres_t r;
    in_tvalid = 1'b1;
    in_tuser = it.bias;
    in_tdata = {6'd0, it.weight, it.act, it.delta, it.idx};
    do @(posedge clk); while (!in_tready);
    r = adam_update(it);
    if (typed) r.weight = tw;
    weight_q.push_back(r);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input(input int cycles);
    in_tvalid = 1'b0;
    in_tdata = IN_TDATA_W'({$urandom(), $urandom(), $urandom(), $urandom()});
    in_tuser = 1'($urandom_range(0, 1));
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 131071)) - 65536);
      3, 4: return 32'(signed'($urandom_range(0, 2097151)) - 1048576);
      default: return $urandom();
    endcase
  endfunction

  function automatic upd_t random_update(input logic [9:0] hot_base);
    upd_t it;
    it.idx = ($urandom_range(0, 9) < 7) ? hot_base + 10'($urandom_range(0, 7))
                                        : 10'($urandom());
    it.bias = $urandom_range(0, 3) == 0;
    it.delta = pick_value();
    it.act = pick_value();
    it.weight = ($urandom_range(0, 5) == 0) ? pick_value() : $urandom();
    return it;
  endfunction

  // Burst of random updates with gaps between bursts.
  task automatic random_phase(input int count);
    int left, burst;
    logic [9:0] base;
    base = 10'($urandom());
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        send_update(random_update(base), 1'b0, '0);
        left--;
      end
      idle_input($urandom_range(0, 6));
    end
  endtask

  // Receiver: stall pattern that changes at random.
  initial begin
    int mode;
    logic [7:0] mask;
    mode = 0;
    mask = 8'hFF;
    forever begin
      @(negedge clk);
      if (($urandom_range(0, 63) == 0)) begin
        mode = $urandom_range(0, 3);
        mask = 8'($urandom());
      end
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = 1'($urandom_range(0, 1));
        2: out_tready = mask[$urandom_range(0, 7)];
        default: out_tready = ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    wres_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (weight_q.size() == 0) begin
        $error("unexpected result: new_weight %h result_index %0d",
               out_tdata[31:0], out_tdata[41:32]);
        n_fail++;
      end else begin
        e = weight_q.pop_front();
        n_checked++;
        if (out_tdata[31:0] !== e.weight) begin
          $error("new_weight: expected %h, actual %h", e.weight, out_tdata[31:0]);
          n_fail++;
        end
        if (out_tdata[41:32] !== e.idx) begin
          $error("result_index: expected %0d, actual %0d", e.idx, out_tdata[41:32]);
          n_fail++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    row_t rows [$];
    row_t rw;
    lr_q = LR_RST;
    b1_q = B1_RST;
    b2_q = B2_RST;
    c1_q = C1_RST;
    c2_q = C2_RST;
    for (int i = 0; i < NPARAM; i++) begin
      first_mom[i] = '0;
      second_mom[i] = '0;
    end

    // Directed rows: zero moments echo the weight, then the field extremes.
    rows = '{
      '{'{10'd0,    1'b0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1, 32'h7FFF_FFFF},
      '{'{10'd1023, 1'b1, 32'h0, 32'h8000_0000, 32'h8000_0000}, 1'b1, 32'h8000_0000},
      '{'{10'd5,    1'b0, 32'h1234_5678, 32'h0, 32'h0001_0000}, 1'b1, 32'h0001_0000},
      '{'{10'd6,    1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1, 32'h0},
      '{'{10'd10,   1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0}, 1'b0, 32'h0},
      '{'{10'd11,   1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, 32'h0},
      '{'{10'd12,   1'b1, 32'h8000_0000, 32'h0, 32'h8000_0000}, 1'b0, 32'h0},
      '{'{10'd13,   1'b1, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF}, 1'b0, 32'h0},
      '{'{10'd20,   1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0010_0000}, 1'b0, 32'h0},
      '{'{10'd20,   1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0010_0000}, 1'b0, 32'h0},
      '{'{10'd20,   1'b0, 32'hFFFF_0000, 32'h0001_0000, 32'h0010_0000}, 1'b0, 32'h0},
      '{'{10'd20,   1'b1, 32'h0000_0001, 32'h0, 32'hFFF0_0000}, 1'b0, 32'h0},
      '{'{10'd1023, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0001}, 1'b0, 32'h0},
      '{'{10'd1023, 1'b0, 32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFE}, 1'b0, 32'h0},
      '{'{10'd0,    1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555}, 1'b0, 32'h0},
      '{'{10'd0,    1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA}, 1'b0, 32'h0},
      '{'{10'h2AA,  1'b0, 32'h0000_8000, 32'hFFFF_8000, 32'h0}, 1'b0, 32'h0},
      '{'{10'h155,  1'b1, 32'h0000_0100, 32'h0, 32'h0}, 1'b0, 32'h0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // The core clears its moment stores after reset; writes wait that out.
    repeat (CLEAR_CYC + 20) @(negedge clk);

    foreach (rows[i]) begin
      rw = rows[i];
      send_update(rw.it, rw.typed, rw.weight);
      if (i % 5 == 4) idle_input($urandom_range(1, 3));
    end
    idle_input(1);

    // Largest settings: huge corrections can saturate the new weight.
    load_regs(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(200);
    idle_input(1);
    // Smallest settings, zero corrections included.
    load_regs(24'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    random_phase(120);
    idle_input(1);
    load_regs(24'hFF_FFFF, 16'd0, 16'hFFFF, 32'd65536, 32'd0);
    random_phase(150);
    idle_input(1);
    load_regs(LR_RST, B1_RST, B2_RST, C1_RST, C2_RST);
    random_phase(280);
    idle_input(1);
    for (int p = 0; p < 4; p++) begin
      load_regs(24'($urandom()), 16'($urandom()), 16'($urandom()),
                32'd65536 + $urandom_range(0, 1 << 24), $urandom());
      random_phase(200);
      idle_input(1);
    end

    // Drain.
    wait (weight_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d parameter updates in %0d register settings; %0d results checked.",
             n_sent, n_phases + 1, n_checked);
    if (n_fail == 0) begin
      $display("[adam_parameter_update_core] OK");
    end else begin
      $display("[adam_parameter_update_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: adam_parameter_update_core.f
+incdir+hdl
hdl/adampu_pkg.sv
hdl/adampu_root_div.sv
hdl/adam_parameter_update_core.sv
test/tb_top.sv
